FILE: hw/rtl/ffha_pkg.sv
package ffha_pkg;

    localparam int HEAP_BYTES   = 65536;
    localparam int HEADER_BYTES = 20;
    localparam int TABLE_DEPTH  = (HEAP_BYTES + 3) / 4;
    localparam int IDX_W        = $clog2(TABLE_DEPTH);
    localparam int ADDR_W       = 16;
    localparam int SIZE_W       = 17;
    localparam int LIMIT_W      = 17;

    localparam logic [SIZE_W-1:0]  HDR_SZ     = SIZE_W'(HEADER_BYTES);
    localparam logic [SIZE_W-1:0]  SPLIT_MIN  = SIZE_W'(HEADER_BYTES + 4);
    localparam logic [LIMIT_W-1:0] LIMIT_RST  = LIMIT_W'(65536);
    localparam logic [LIMIT_W-1:0] BOUND_MAX  =
        (HEAP_BYTES < 65536) ? LIMIT_W'(HEAP_BYTES) : LIMIT_W'(65536);

    localparam logic [1:0] CMD_ALLOC     = 2'd0;
    localparam logic [1:0] CMD_FREE      = 2'd1;
    localparam logic [1:0] CMD_REALLOC   = 2'd2;
    localparam logic [1:0] CMD_REALLOC_F = 2'd3;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_NOSPACE = 2'd1;
    localparam logic [1:0] STATUS_INVALID = 2'd2;

    localparam logic [2:0] REG_HEAP_LIMIT = 3'd0;

    typedef struct packed {
        logic               present;
        logic               is_free;
        logic               has_next;
        logic               has_prev;
        logic [ADDR_W-1:0]  hdr;
        logic [SIZE_W-1:0]  size;
        logic [ADDR_W-1:0]  next;
        logic [ADDR_W-1:0]  prev;
    } t_hdr;

    typedef struct packed {
        logic              rd_en;
        logic [IDX_W-1:0]  rd_idx;
        logic              wr_en;
        logic [IDX_W-1:0]  wr_idx;
        t_hdr              wr_data;
    } t_mem_req;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_DECODE, ST_VB, ST_VB_CHK,
        ST_RA_EVAL, ST_RA_NCHK, ST_RA_SPLIT, ST_MOVE,
        ST_AL_START, ST_AL_CHK, ST_AL_TAKE, ST_GROW, ST_GROW_LINK, ST_AL_FIN,
        ST_SP_CHK, ST_SP_WR, ST_SP_LINK,
        ST_MG_RD, ST_MG_CHK, ST_MG_LINK, ST_MG_END,
        ST_REL_LOAD, ST_REL_LOADED, ST_REL_START, ST_REL_PREV, ST_REL_MID,
        ST_REL_TAIL, ST_DONE
    } t_state;

    function automatic logic [IDX_W-1:0] slot_of(input logic [ADDR_W-1:0] a);
        return a[ADDR_W-1:2];
    endfunction

endpackage

FILE: hw/rtl/ffha_req_if.sv
interface ffha_req_if import ffha_pkg::*; ;
    logic              valid;
    logic              ready;
    logic [1:0]        cmd;
    logic [ADDR_W-1:0] address;
    logic [15:0]       request_size;

    modport source (output valid, cmd, address, request_size, input ready);
    modport sink   (input valid, cmd, address, request_size, output ready);
endinterface

FILE: hw/rtl/ffha_rsp_if.sv
interface ffha_rsp_if import ffha_pkg::*; ;
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [ADDR_W-1:0] result_address;
    logic              moved;
    logic [ADDR_W-1:0] old_address;
    logic [15:0]       copy_bytes;

    modport source (output valid, status, result_address, moved, old_address, copy_bytes,
                    input ready);
    modport sink   (input valid, status, result_address, moved, old_address, copy_bytes,
                    output ready);
endinterface

FILE: hw/rtl/ffha_hdr_mem.sv
module ffha_hdr_mem import ffha_pkg::*; (
    input  logic     i_clk,
    input  t_mem_req i_req,
    output t_hdr     o_rd_data
);

    t_hdr r_mem [TABLE_DEPTH];
    t_hdr r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_idx] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_idx];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hw/rtl/ffha_seq.sv
module ffha_seq import ffha_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [LIMIT_W-1:0] i_heap_limit,
    ffha_req_if.sink           i_req,
    ffha_rsp_if.source         o_rsp,
    output t_mem_req           o_mem,
    input  t_hdr               i_rd_data
);

    t_state r_state, n_state;
    t_state r_sret, r_mret;

    logic [IDX_W-1:0]   r_clr;
    logic [1:0]         r_cmd;
    logic [ADDR_W-1:0]  r_p;
    logic [SIZE_W-1:0]  r_s;
    logic [ADDR_W-1:0]  r_h, r_hold, r_cur, r_last, r_nh, r_laddr, r_maddr, r_nd;
    t_hdr               r_e, r_n;
    logic               r_has_last, r_slink, r_move, r_afail;
    logic [SIZE_W-1:0]  r_old_size, r_new_size;
    logic [SIZE_W-1:0]  r_top;
    logic               r_nonempty;

    logic [1:0]         r_status;
    logic [ADDR_W-1:0]  r_res, r_old;
    logic               r_moved;
    logic [15:0]        r_copy;

    logic               r_ovalid;
    logic [1:0]         r_o_status;
    logic [ADDR_W-1:0]  r_o_res, r_o_old;
    logic               r_o_moved;
    logic [15:0]        r_o_copy;

    logic               accept, out_free;
    logic [SIZE_W-1:0]  vb_h;
    logic               vb_bad, vb_ok, al_fit, ra_fit, ra_nfit, grow_ok, split_do;
    logic [SIZE_W:0]    grow_end, nfit_sum, nh_sum;
    logic [LIMIT_W-1:0] bound;
    logic [ADDR_W-1:0]  nh;
    logic [SIZE_W-1:0]  copy_min;
    t_hdr               new_blk, split_blk;

    assign accept   = i_req.valid && i_req.ready;
    assign out_free = !r_ovalid || o_rsp.ready;
    assign i_req.ready = (r_state == ST_IDLE);

    assign bound    = (i_heap_limit > BOUND_MAX) ? BOUND_MAX : i_heap_limit;
    assign vb_h     = {1'b0, r_p} - HDR_SZ;
    assign vb_bad   = !r_nonempty || ({1'b0, r_p} < HDR_SZ) || (vb_h >= r_top);
    assign vb_ok    = i_rd_data.present && (i_rd_data.hdr == vb_h[ADDR_W-1:0])
                      && !i_rd_data.is_free;
    assign al_fit   = i_rd_data.is_free && (i_rd_data.size >= r_s);
    assign ra_fit   = r_e.size >= r_s;
    assign nfit_sum = {1'b0, r_e.size} + {1'b0, HDR_SZ} + {1'b0, i_rd_data.size};
    assign ra_nfit  = i_rd_data.is_free && (nfit_sum >= {1'b0, r_s});
    assign grow_end = {1'b0, r_top} + {1'b0, HDR_SZ} + {1'b0, r_s};
    assign grow_ok  = ({1'b0, r_top} + {1'b0, HDR_SZ} <= (SIZE_W+1)'(65535))
                      && (grow_end <= {1'b0, bound});
    assign split_do = (r_e.size - r_s) >= SPLIT_MIN;
    assign nh_sum   = {2'b0, r_h} + {1'b0, HDR_SZ} + {1'b0, r_s};
    assign nh       = nh_sum[ADDR_W-1:0];
    assign copy_min = (r_old_size < r_new_size) ? r_old_size : r_new_size;

    always_comb begin
        new_blk          = '0;
        new_blk.present  = 1'b1;
        new_blk.hdr      = r_top[ADDR_W-1:0];
        new_blk.size     = r_s;
        new_blk.has_prev = r_has_last;
        new_blk.prev     = r_last;
        split_blk          = '0;
        split_blk.present  = 1'b1;
        split_blk.is_free  = 1'b1;
        split_blk.hdr      = nh;
        split_blk.size     = r_e.size - r_s - HDR_SZ;
        split_blk.has_next = r_e.has_next;
        split_blk.next     = r_e.next;
        split_blk.has_prev = 1'b1;
        split_blk.prev     = r_h;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR:      if (r_clr == IDX_W'(TABLE_DEPTH - 1)) n_state = ST_IDLE;
            ST_IDLE:       if (accept) n_state = ST_DECODE;
            ST_DECODE: begin
                if (r_cmd == CMD_ALLOC || (r_cmd != CMD_FREE && r_p == '0)) begin
                    n_state = ST_AL_START;
                end else if (r_cmd == CMD_FREE && r_p == '0) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_VB;
                end
            end
            ST_VB:         n_state = vb_bad ? ST_DONE : ST_VB_CHK;
            ST_VB_CHK: begin
                if (!vb_ok)                 n_state = ST_DONE;
                else if (r_cmd == CMD_FREE) n_state = ST_REL_START;
                else                        n_state = ST_RA_EVAL;
            end
            ST_RA_EVAL: begin
                if (ra_fit)              n_state = ST_SP_CHK;
                else if (r_e.has_next)   n_state = ST_RA_NCHK;
                else                     n_state = ST_MOVE;
            end
            ST_RA_NCHK:    n_state = ra_nfit ? ST_MG_RD : ST_MOVE;
            ST_RA_SPLIT:   n_state = ST_SP_CHK;
            ST_MOVE:       n_state = ST_AL_START;
            ST_AL_START:   n_state = r_nonempty ? ST_AL_CHK : ST_GROW;
            ST_AL_CHK: begin
                if (al_fit)                  n_state = ST_SP_CHK;
                else if (i_rd_data.has_next) n_state = ST_AL_CHK;
                else                         n_state = ST_GROW;
            end
            ST_AL_TAKE:    n_state = ST_AL_FIN;
            ST_GROW:       n_state = (grow_ok && r_has_last) ? ST_GROW_LINK : ST_AL_FIN;
            ST_GROW_LINK:  n_state = ST_AL_FIN;
            ST_AL_FIN: begin
                if (r_afail) n_state = (r_move && r_cmd == CMD_REALLOC_F) ? ST_REL_LOAD : ST_DONE;
                else         n_state = r_move ? ST_REL_LOAD : ST_DONE;
            end
            ST_SP_CHK:     n_state = split_do ? ST_SP_WR : r_sret;
            ST_SP_WR:      n_state = r_slink ? ST_SP_LINK : r_sret;
            ST_SP_LINK:    n_state = r_sret;
            ST_MG_RD:      n_state = r_e.has_next ? ST_MG_CHK : ST_MG_END;
            ST_MG_CHK:     n_state = (i_rd_data.is_free && i_rd_data.has_next) ? ST_MG_LINK
                                                                                 : ST_MG_END;
            ST_MG_LINK:    n_state = ST_MG_END;
            ST_MG_END:     n_state = r_mret;
            ST_REL_LOAD:   n_state = ST_REL_LOADED;
            ST_REL_LOADED: n_state = ST_REL_START;
            ST_REL_START:  n_state = r_e.has_prev ? ST_REL_PREV : ST_REL_MID;
            ST_REL_PREV:   n_state = i_rd_data.is_free ? ST_MG_RD : ST_REL_MID;
            ST_REL_MID: begin
                if (r_e.has_next)      n_state = ST_MG_RD;
                else if (r_e.has_prev) n_state = ST_REL_TAIL;
                else                   n_state = ST_DONE;
            end
            ST_REL_TAIL:   n_state = ST_DONE;
            ST_DONE:       if (out_free) n_state = ST_IDLE;
            default:       n_state = ST_IDLE;
        endcase
    end

    // memory port
    always_comb begin
        o_mem = '0;
        case (r_state)
            ST_CLEAR: begin
                o_mem.wr_en  = 1'b1;
                o_mem.wr_idx = r_clr;
            end
            ST_VB: begin
                o_mem.rd_en  = !vb_bad;
                o_mem.rd_idx = slot_of(vb_h[ADDR_W-1:0]);
            end
            ST_RA_EVAL: begin
                o_mem.rd_en  = !ra_fit && r_e.has_next;
                o_mem.rd_idx = slot_of(r_e.next);
            end
            ST_AL_START: begin
                o_mem.rd_en  = r_nonempty;
                o_mem.rd_idx = '0;
            end
            ST_AL_CHK: begin
                o_mem.rd_en  = !al_fit && i_rd_data.has_next;
                o_mem.rd_idx = slot_of(i_rd_data.next);
            end
            ST_AL_TAKE: begin
                o_mem.wr_en           = 1'b1;
                o_mem.wr_idx          = slot_of(r_h);
                o_mem.wr_data         = r_e;
                o_mem.wr_data.is_free = 1'b0;
            end
            ST_GROW: begin
                o_mem.wr_en   = grow_ok;
                o_mem.wr_idx  = slot_of(r_top[ADDR_W-1:0]);
                o_mem.wr_data = new_blk;
            end
            ST_GROW_LINK: begin
                o_mem.wr_en            = 1'b1;
                o_mem.wr_idx           = slot_of(r_last);
                o_mem.wr_data          = r_n;
                o_mem.wr_data.has_next = 1'b1;
                o_mem.wr_data.next     = r_nd - ADDR_W'(HEADER_BYTES);
            end
            ST_SP_CHK: begin
                o_mem.wr_en   = split_do;
                o_mem.wr_idx  = slot_of(nh);
                o_mem.wr_data = split_blk;
                o_mem.rd_en   = split_do && r_e.has_next;
                o_mem.rd_idx  = slot_of(r_e.next);
            end
            ST_SP_WR: begin
                o_mem.wr_en   = 1'b1;
                o_mem.wr_idx  = slot_of(r_h);
                o_mem.wr_data = r_e;
            end
            ST_SP_LINK: begin
                o_mem.wr_en        = 1'b1;
                o_mem.wr_idx       = slot_of(r_laddr);
                o_mem.wr_data      = r_n;
                o_mem.wr_data.prev = r_nh;
            end
            ST_MG_RD: begin
                o_mem.rd_en  = r_e.has_next;
                o_mem.rd_idx = slot_of(r_e.next);
            end
            ST_MG_CHK: begin
                o_mem.wr_en           = i_rd_data.is_free;
                o_mem.wr_idx          = slot_of(r_maddr);
                o_mem.wr_data         = i_rd_data;
                o_mem.wr_data.present = 1'b0;
                o_mem.rd_en           = i_rd_data.is_free && i_rd_data.has_next;
                o_mem.rd_idx          = slot_of(i_rd_data.next);
            end
            ST_MG_LINK: begin
                o_mem.wr_en        = 1'b1;
                o_mem.wr_idx       = slot_of(r_maddr);
                o_mem.wr_data      = i_rd_data;
                o_mem.wr_data.prev = r_h;
            end
            ST_MG_END: begin
                o_mem.wr_en   = 1'b1;
                o_mem.wr_idx  = slot_of(r_h);
                o_mem.wr_data = r_e;
            end
            ST_REL_LOAD: begin
                o_mem.rd_en  = 1'b1;
                o_mem.rd_idx = slot_of(r_hold);
            end
            ST_REL_START: begin
                o_mem.wr_en           = 1'b1;
                o_mem.wr_idx          = slot_of(r_h);
                o_mem.wr_data         = r_e;
                o_mem.wr_data.is_free = 1'b1;
                o_mem.rd_en           = r_e.has_prev;
                o_mem.rd_idx          = slot_of(r_e.prev);
            end
            ST_REL_MID: begin
                o_mem.wr_en           = !r_e.has_next;
                o_mem.wr_idx          = slot_of(r_h);
                o_mem.wr_data         = r_e;
                o_mem.wr_data.present = 1'b0;
                o_mem.rd_en           = !r_e.has_next && r_e.has_prev;
                o_mem.rd_idx          = slot_of(r_e.prev);
            end
            ST_REL_TAIL: begin
                o_mem.wr_en            = 1'b1;
                o_mem.wr_idx           = slot_of(r_e.prev);
                o_mem.wr_data          = i_rd_data;
                o_mem.wr_data.has_next = 1'b0;
            end
            default: o_mem = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr      <= '0;
            r_top      <= '0;
            r_nonempty <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_DONE && out_free) begin
                r_ovalid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_CLEAR: r_clr <= r_clr + 1'b1;
                ST_IDLE: begin
                    if (accept) begin
                        r_cmd    <= i_req.cmd;
                        r_p      <= i_req.address;
                        r_s      <= ({1'b0, i_req.request_size} + SIZE_W'(3)) & ~SIZE_W'(3);
                        r_status <= STATUS_OK;
                        r_res    <= '0;
                        r_old    <= '0;
                        r_moved  <= 1'b0;
                        r_copy   <= '0;
                        r_move   <= 1'b0;
                        r_afail  <= 1'b0;
                    end
                end
                ST_VB: begin
                    if (vb_bad) r_status <= STATUS_INVALID;
                    else        r_h      <= vb_h[ADDR_W-1:0];
                end
                ST_VB_CHK: begin
                    if (vb_ok) r_e      <= i_rd_data;
                    else       r_status <= STATUS_INVALID;
                end
                ST_RA_EVAL: begin
                    if (ra_fit) begin
                        r_res  <= r_p;
                        r_sret <= ST_DONE;
                    end
                end
                ST_RA_NCHK: begin
                    if (ra_nfit) begin
                        r_res  <= r_p;
                        r_mret <= ST_RA_SPLIT;
                    end
                end
                ST_RA_SPLIT: r_sret <= ST_DONE;
                ST_MOVE: begin
                    r_old_size <= r_e.size;
                    r_move     <= 1'b1;
                    r_hold     <= r_h;
                end
                ST_AL_START: begin
                    r_cur      <= '0;
                    r_has_last <= 1'b0;
                end
                ST_AL_CHK: begin
                    if (al_fit) begin
                        r_h    <= r_cur;
                        r_e    <= i_rd_data;
                        r_sret <= ST_AL_TAKE;
                    end else begin
                        r_last <= r_cur;
                        r_n    <= i_rd_data;
                        if (i_rd_data.has_next) r_cur      <= i_rd_data.next;
                        else                    r_has_last <= 1'b1;
                    end
                end
                ST_AL_TAKE: begin
                    r_nd       <= r_h + ADDR_W'(HEADER_BYTES);
                    r_new_size <= r_e.size;
                end
                ST_GROW: begin
                    if (grow_ok) begin
                        r_nd       <= r_top[ADDR_W-1:0] + ADDR_W'(HEADER_BYTES);
                        r_new_size <= r_s;
                        r_top      <= grow_end[SIZE_W-1:0];
                        r_nonempty <= 1'b1;
                    end else begin
                        r_afail <= 1'b1;
                    end
                end
                ST_AL_FIN: begin
                    r_h <= r_hold;
                    if (r_afail) begin
                        r_status <= STATUS_NOSPACE;
                        r_res    <= '0;
                    end else begin
                        r_res <= r_nd;
                        if (r_move) begin
                            r_moved <= 1'b1;
                            r_old   <= r_p;
                            r_copy  <= copy_min[SIZE_W-1:16] != '0 ? 16'hFFFF : copy_min[15:0];
                        end
                    end
                end
                ST_SP_CHK: begin
                    if (split_do) begin
                        r_nh         <= nh;
                        r_laddr      <= r_e.next;
                        r_slink      <= r_e.has_next;
                        r_e.size     <= r_s;
                        r_e.has_next <= 1'b1;
                        r_e.next     <= nh;
                    end
                end
                ST_SP_WR:  r_n <= i_rd_data;
                ST_MG_RD:  r_maddr <= r_e.next;
                ST_MG_CHK: begin
                    if (i_rd_data.is_free) begin
                        r_e.size     <= r_e.size + HDR_SZ + i_rd_data.size;
                        r_e.has_next <= i_rd_data.has_next;
                        r_e.next     <= i_rd_data.next;
                        r_maddr      <= i_rd_data.next;
                    end
                end
                ST_REL_LOADED: r_e <= i_rd_data;
                ST_REL_START:  r_e.is_free <= 1'b1;
                ST_REL_PREV: begin
                    if (i_rd_data.is_free) begin
                        r_h    <= r_e.prev;
                        r_e    <= i_rd_data;
                        r_mret <= ST_REL_MID;
                    end
                end
                ST_REL_MID: begin
                    if (r_e.has_next) begin
                        r_mret <= ST_DONE;
                    end else begin
                        // tail block goes back to the heap top
                        r_top <= {1'b0, r_h};
                        if (!r_e.has_prev) r_nonempty <= 1'b0;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_o_status <= r_status;
                        r_o_res    <= r_res;
                        r_o_moved  <= r_moved;
                        r_o_old    <= r_old;
                        r_o_copy   <= r_copy;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_rsp.valid          = r_ovalid;
    assign o_rsp.status         = r_o_status;
    assign o_rsp.result_address = r_o_res;
    assign o_rsp.moved          = r_o_moved;
    assign o_rsp.old_address    = r_o_old;
    assign o_rsp.copy_bytes     = r_o_copy;

    a_no_rw_same_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_mem.rd_en && o_mem.wr_en) |-> (o_mem.rd_idx != o_mem.wr_idx))
        else $error("read and write of the same header slot in one cycle");

    a_empty_top_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && !r_nonempty) |-> (r_top == '0))
        else $error("empty heap with non-zero top");

    a_fail_no_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_o_status != STATUS_OK) |-> (r_o_res == '0 && !r_o_moved))
        else $error("failed transaction carries an address");

    a_move_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_o_moved) |-> (r_o_old != '0 && r_o_res != '0))
        else $error("moved block without source or destination");

    a_top_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top <= SIZE_W'(BOUND_MAX))
        else $error("heap top beyond the heap");

endmodule

FILE: hw/rtl/first_fit_heap_allocator.sv
// channel   direction  handshake      payload
// i_req     in         valid/ready    cmd, address, request_size
// o_rsp     out        valid/ready    status, result_address, moved, old_address, copy_bytes
// apb       in         psel/penable   heap_limit at byte address 0
//
// One request at a time; a result sits in an output register, so the next
// request is taken while it waits. An allocation walks the block list with one
// header memory read per block walked; each split, merge or link update adds
// states of its own. A result still waiting stalls the following request at
// its end. After reset a clearing pass wipes the header memory; no request is
// taken until it completes.
module first_fit_heap_allocator import ffha_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ffha_req_if.sink    i_req,
    ffha_rsp_if.source  o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [LIMIT_W-1:0] r_heap_limit;
    t_mem_req           mem_req;
    t_hdr               rd_data;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_limit <= LIMIT_RST;
        end else if (psel && penable && pwrite && paddr == REG_HEAP_LIMIT) begin
            r_heap_limit <= pwdata[LIMIT_W-1:0];
        end
    end

    assign prdata = (paddr == REG_HEAP_LIMIT) ? {{(32-LIMIT_W){1'b0}}, r_heap_limit} : '0;

    ffha_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_heap_limit (r_heap_limit),
        .i_req        (i_req),
        .o_rsp        (o_rsp),
        .o_mem        (mem_req),
        .i_rd_data    (rd_data)
    );

    ffha_hdr_mem u_mem (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

endmodule
